// ----- src/oss_pkg.sv -----
`default_nettype none

package oss_pkg;

    // Default geometry of the store
    localparam int DEFAULT_SIZE  = 16;
    localparam int DEFAULT_WIDTH = 32;

    // Item kinds on the input channel
    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_READ,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- src/oss_ram.sv -----
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data.
module oss_ram #(
    parameter int DEPTH = oss_pkg::DEFAULT_SIZE,
    parameter int WIDTH = oss_pkg::DEFAULT_WIDTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/ordered_set_store.sv -----
`default_nettype none

// Channel   Handshake           Payload
// s_        s_valid / s_ready   s_kind, s_value, s_position
// m_        m_valid / m_ready   m_found, m_read_value, m_count, m_status
//
// One item at a time; the entries sit in one RAM, read one per cycle. A scan reads
// the entries in order and stops at a hit; a remove that hits then closes the gap by
// moving each later entry down one place. A read of a position out of range skips
// the RAM. s_ready returns as the result enters the output register; a full output
// register holds the result back.
// Reset (aresetn low, synchronous) empties the set; the RAM is not cleared.

module ordered_set_store #(
    parameter int SIZE  = oss_pkg::DEFAULT_SIZE,
    parameter int WIDTH = oss_pkg::DEFAULT_WIDTH
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic        [1:0]  s_kind,
    input  wire logic signed [31:0] s_value,
    input  wire logic        [3:0]  s_position,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_found,
    output logic signed      [31:0] m_read_value,
    output logic             [4:0]  m_count,
    output logic             [1:0]  m_status
);

    localparam int AW = (SIZE > 1) ? $clog2(SIZE) : 1;   // RAM address
    localparam int CW = $clog2(SIZE + 1);                // count 0..SIZE
    localparam int PW = (CW > 4) ? CW : 4;               // position compare

    // Control state
    oss_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]    used_reg, used_next;
    logic             pend_reg, pend_next;
    logic             m_valid_reg, m_valid_next;

    // Item and result payload
    oss_pkg::kind_t   kind_reg, kind_next;
    logic [WIDTH-1:0] key_reg, key_next;
    logic [CW-1:0]    rd_idx_reg, rd_idx_next;
    logic [AW-1:0]    pend_idx_reg, pend_idx_next;
    logic             res_found_reg, res_found_next;
    oss_pkg::status_t res_status_reg, res_status_next;
    logic [31:0]      res_rd_reg, res_rd_next;
    logic             m_found_reg, m_found_next;
    logic [31:0]      m_read_value_reg, m_read_value_next;
    logic [4:0]       m_count_reg, m_count_next;
    oss_pkg::status_t m_status_reg, m_status_next;

    // RAM port
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [WIDTH-1:0] mem_wd;
    logic             mem_re;
    logic [AW-1:0]    mem_ra;
    logic [WIDTH-1:0] mem_rdata;

    logic [PW-1:0]    pos_w;
    logic [PW-1:0]    used_w;
    logic             hit;
    logic             more;

    oss_ram #(
        .DEPTH (SIZE),
        .WIDTH (WIDTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_wa),
        .wr_data (mem_wd),
        .rd_en   (mem_re),
        .rd_addr (mem_ra),
        .rd_data (mem_rdata)
    );

    assign pos_w  = PW'(s_position);
    assign used_w = PW'(used_reg);
    assign hit    = pend_reg && (mem_rdata == key_reg);
    assign more   = rd_idx_reg < used_reg;

    assign s_ready      = (state_reg == oss_pkg::ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_found      = m_found_reg;
    assign m_read_value = m_read_value_reg;
    assign m_count      = m_count_reg;
    assign m_status     = m_status_reg;

    // Sequencer: next state, RAM accesses and result
    always_comb begin
        state_next        = state_reg;
        used_next         = used_reg;
        pend_next         = pend_reg;
        m_valid_next      = m_valid_reg;
        kind_next         = kind_reg;
        key_next          = key_reg;
        rd_idx_next       = rd_idx_reg;
        pend_idx_next     = pend_idx_reg;
        res_found_next    = res_found_reg;
        res_status_next   = res_status_reg;
        res_rd_next       = res_rd_reg;
        m_found_next      = m_found_reg;
        m_read_value_next = m_read_value_reg;
        m_count_next      = m_count_reg;
        m_status_next     = m_status_reg;
        mem_we            = 1'b0;
        mem_wa            = '0;
        mem_wd            = key_reg;
        mem_re            = 1'b0;
        mem_ra            = '0;

        // result taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            oss_pkg::ST_IDLE: begin
                if (s_valid) begin
                    kind_next       = oss_pkg::kind_t'(s_kind);
                    key_next        = WIDTH'($unsigned(s_value));
                    res_found_next  = 1'b0;
                    res_status_next = oss_pkg::STATUS_OK;
                    res_rd_next     = '0;
                    rd_idx_next     = '0;
                    pend_next       = 1'b0;
                    if (oss_pkg::kind_t'(s_kind) == oss_pkg::KIND_READ) begin
                        if (pos_w < used_w) begin
                            mem_re     = 1'b1;
                            mem_ra     = pos_w[AW-1:0];
                            state_next = oss_pkg::ST_READ;
                        end else begin
                            res_status_next = oss_pkg::STATUS_RANGE;
                            state_next      = oss_pkg::ST_DONE;
                        end
                    end else begin
                        state_next = oss_pkg::ST_SCAN;
                    end
                end
            end

            // read entries in order, compare each entry in the cycle after its read
            oss_pkg::ST_SCAN: begin
                if (hit) begin
                    res_found_next = 1'b1;
                    pend_next      = 1'b0;
                    if (kind_reg == oss_pkg::KIND_REMOVE) begin
                        rd_idx_next = CW'(pend_idx_reg) + CW'(1);
                        state_next  = oss_pkg::ST_SHIFT;
                    end else begin
                        state_next = oss_pkg::ST_DONE;
                    end
                end else if (!pend_reg && !more) begin
                    // not held
                    if (kind_reg == oss_pkg::KIND_INSERT) begin
                        if (used_reg < CW'(SIZE)) begin
                            mem_we    = 1'b1;
                            mem_wa    = used_reg[AW-1:0];
                            used_next = used_reg + CW'(1);
                        end else begin
                            res_status_next = oss_pkg::STATUS_FULL;
                        end
                    end
                    state_next = oss_pkg::ST_DONE;
                end else if (more) begin
                    mem_re        = 1'b1;
                    mem_ra        = rd_idx_reg[AW-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[AW-1:0];
                    rd_idx_next   = rd_idx_reg + CW'(1);
                end else begin
                    pend_next = 1'b0;
                end
            end

            // close the gap: entry i+1 read, written back at i next cycle
            oss_pkg::ST_SHIFT: begin
                if (pend_reg) begin
                    mem_we = 1'b1;
                    mem_wa = pend_idx_reg - AW'(1);
                    mem_wd = mem_rdata;
                end
                if (more) begin
                    mem_re        = 1'b1;
                    mem_ra        = rd_idx_reg[AW-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[AW-1:0];
                    rd_idx_next   = rd_idx_reg + CW'(1);
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        used_next  = used_reg - CW'(1);
                        state_next = oss_pkg::ST_DONE;
                    end
                end
            end

            oss_pkg::ST_READ: begin
                res_rd_next = 32'($signed(mem_rdata));
                state_next  = oss_pkg::ST_DONE;
            end

            // hand the result to the output register once it is free
            oss_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_found_next      = res_found_reg;
                    m_read_value_next = res_rd_reg;
                    m_count_next      = 5'(used_reg);
                    m_status_next     = res_status_reg;
                    state_next        = oss_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = oss_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= oss_pkg::ST_IDLE;
            used_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        kind_reg         <= kind_next;
        key_reg          <= key_next;
        rd_idx_reg       <= rd_idx_next;
        pend_idx_reg     <= pend_idx_next;
        res_found_reg    <= res_found_next;
        res_status_reg   <= res_status_next;
        res_rd_reg       <= res_rd_next;
        m_found_reg      <= m_found_next;
        m_read_value_reg <= m_read_value_next;
        m_count_reg      <= m_count_next;
        m_status_reg     <= m_status_next;
    end

endmodule

`default_nettype wire

// ----- dv/tb_ordered_set_store.sv -----
`timescale 1ns / 100ps

module tb_ordered_set_store;

    localparam int SET_SIZE    = oss_pkg::DEFAULT_SIZE;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 217;
    localparam int DRAIN_WAIT  = 60;

    // One result as the block reports it
    typedef struct packed {
        logic               found;
        logic signed [31:0] read_value;
        logic [4:0]         count;
        oss_pkg::status_t   status;
    } set_result_t;

    // One directed item; want is used only when pinned is set
    typedef struct packed {
        oss_pkg::kind_t kind;
        logic [31:0]    value;
        logic [3:0]     position;
        logic           pinned;
        set_result_t    want;
    } stim_row_t;

    localparam set_result_t NO_WANT = '0;

    logic        aclk;
    logic        aresetn    = 1'b0;
    logic        s_valid    = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind     = '0;
    logic [31:0] s_value    = '0;
    logic [3:0]  s_position = '0;
    logic        m_valid;
    logic        m_ready    = 1'b0;
    logic        m_found;
    logic [31:0] m_read_value;
    logic [4:0]  m_count;
    logic [1:0]  m_status;

    // Shadow copy of the set, in insertion order
    logic [31:0] held_words [SET_SIZE];
    int          held_count = 0;

    set_result_t pending_results [$];
    int          mismatch_count = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    bit          hold_request   = 1'b0;

    // Directed items: empty store, extremes, duplicates, full store, gap closing
    stim_row_t directed_rows [27] = '{
        '{oss_pkg::KIND_READ,   32'h0000_0000, 4'd0,  1'b1,
          '{1'b0, 32'sd0, 5'd0, oss_pkg::STATUS_RANGE}},
        '{oss_pkg::KIND_QUERY,  32'h0000_0000, 4'd0,  1'b1,
          '{1'b0, 32'sd0, 5'd0, oss_pkg::STATUS_OK}},
        '{oss_pkg::KIND_REMOVE, 32'h0000_0005, 4'd0,  1'b1,
          '{1'b0, 32'sd0, 5'd0, oss_pkg::STATUS_OK}},
        '{oss_pkg::KIND_INSERT, 32'h8000_0000, 4'd0,  1'b1,
          '{1'b0, 32'sd0, 5'd1, oss_pkg::STATUS_OK}},
        '{oss_pkg::KIND_INSERT, 32'h7fff_ffff, 4'd15, 1'b1,
          '{1'b0, 32'sd0, 5'd2, oss_pkg::STATUS_OK}},
        '{oss_pkg::KIND_INSERT, 32'h8000_0000, 4'd0,  1'b1,
          '{1'b1, 32'sd0, 5'd2, oss_pkg::STATUS_OK}},
        '{oss_pkg::KIND_QUERY,  32'h7fff_ffff, 4'd0,  1'b1,
          '{1'b1, 32'sd0, 5'd2, oss_pkg::STATUS_OK}},
        '{oss_pkg::KIND_READ,   32'h0000_0000, 4'd0,  1'b1,
          '{1'b0, 32'sh8000_0000, 5'd2, oss_pkg::STATUS_OK}},
        '{oss_pkg::KIND_READ,   32'hffff_ffff, 4'd15, 1'b1,
          '{1'b0, 32'sd0, 5'd2, oss_pkg::STATUS_RANGE}},
        '{oss_pkg::KIND_INSERT, 32'h0000_0000, 4'd0,  1'b0, NO_WANT},
        '{oss_pkg::KIND_INSERT, 32'hffff_ffff, 4'd0,  1'b0, NO_WANT},
        '{oss_pkg::KIND_INSERT, 32'haaaa_aaaa, 4'd0,  1'b0, NO_WANT},
        '{oss_pkg::KIND_INSERT, 32'h0000_0001, 4'd0,  1'b0, NO_WANT},
        '{oss_pkg::KIND_INSERT, 32'h0000_0002, 4'd0,  1'b0, NO_WANT},
        '{oss_pkg::KIND_INSERT, 32'h0000_0003, 4'd0,  1'b0, NO_WANT},
        '{oss_pkg::KIND_INSERT, 32'h0000_0004, 4'd0,  1'b0, NO_WANT},
        '{oss_pkg::KIND_INSERT, 32'h0000_0005, 4'd0,  1'b0, NO_WANT},
        '{oss_pkg::KIND_INSERT, 32'h0000_0006, 4'd0,  1'b0, NO_WANT},
        '{oss_pkg::KIND_INSERT, 32'h0000_0007, 4'd0,  1'b0, NO_WANT},
        '{oss_pkg::KIND_INSERT, 32'h0000_0008, 4'd0,  1'b0, NO_WANT},
        '{oss_pkg::KIND_INSERT, 32'h0000_0009, 4'd0,  1'b0, NO_WANT},
        '{oss_pkg::KIND_INSERT, 32'h0000_000a, 4'd0,  1'b0, NO_WANT},
        '{oss_pkg::KIND_INSERT, 32'hffff_fff0, 4'd0,  1'b0, NO_WANT},
        '{oss_pkg::KIND_INSERT, 32'h0000_0005, 4'd0,  1'b0, NO_WANT},
        '{oss_pkg::KIND_INSERT, 32'h5555_5555, 4'd0,  1'b1,
          '{1'b0, 32'sd0, 5'd16, oss_pkg::STATUS_FULL}},
        '{oss_pkg::KIND_REMOVE, 32'h8000_0000, 4'd0,  1'b0, NO_WANT},
        '{oss_pkg::KIND_READ,   32'h0000_0000, 4'd15, 1'b1,
          '{1'b0, 32'sd0, 5'd15, oss_pkg::STATUS_RANGE}}
    };

    ordered_set_store dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_value      (s_value),
        .s_position   (s_position),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_read_value (m_read_value),
        .m_count      (m_count),
        .m_status     (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Apply one item to the shadow set and return what the block should report
    function automatic set_result_t apply_set_op(oss_pkg::kind_t kind, logic [31:0] value,
                                                 logic [3:0] position);
        set_result_t r;
        int          slot;
        r    = '{1'b0, 32'sd0, 5'd0, oss_pkg::STATUS_OK};
        slot = -1;
        for (int i = 0; i < held_count; i++) begin
            if (slot < 0 && held_words[i] == value) slot = i;
        end
        case (kind)
            oss_pkg::KIND_INSERT: begin
                if (slot >= 0) r.found = 1'b1;
                else if (held_count >= SET_SIZE) r.status = oss_pkg::STATUS_FULL;
                else begin
                    held_words[held_count] = value;
                    held_count++;
                end
            end
            oss_pkg::KIND_REMOVE: begin
                if (slot >= 0) begin
                    r.found = 1'b1;
                    // close the gap, order of the rest is kept
                    for (int i = slot; i + 1 < held_count; i++)
                        held_words[i] = held_words[i + 1];
                    held_count--;
                end
            end
            oss_pkg::KIND_QUERY: begin
                r.found = (slot >= 0);
            end
            default: begin
                if (position < held_count) r.read_value = held_words[position];
                else r.status = oss_pkg::STATUS_RANGE;
            end
        endcase
        r.count = held_count[4:0];
        return r;
    endfunction

    // Mostly a small pool so values collide, sometimes extremes or any word
    function automatic logic [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7) return 32'($urandom_range(0, 19)) - 32'd10;
        if (roll == 7) return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        return $urandom();
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Offer one item, with a random gap first; valid stays up after the transfer
    task automatic offer_item(oss_pkg::kind_t kind, logic [31:0] value,
                              logic [3:0] position, logic pinned, set_result_t want);
        set_result_t predicted;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_valid    <= 1'b1;
        s_kind     <= kind;
        s_value    <= value;
        s_position <= position;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_set_op(kind, value, position);
        pending_results.push_back(pinned ? want : predicted);
    endtask

    task automatic compare_result();
        set_result_t want;
        if (pending_results.size() == 0) begin
            report_mismatch("result transfer with nothing pending");
            return;
        end
        want = pending_results.pop_front();
        if (m_found !== want.found)
            report_mismatch($sformatf("found %b, want %b", m_found, want.found));
        if (m_read_value !== want.read_value)
            report_mismatch($sformatf("read_value %h, want %h", m_read_value,
                                      want.read_value));
        if (m_count !== want.count)
            report_mismatch($sformatf("count %0d, want %0d", m_count, want.count));
        if (m_status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", m_status, want.status));
    endtask

    // Result side: check transfers, stall at random, one long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) compare_result();
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Stimulus
    initial begin
        int             roll;
        oss_pkg::kind_t kind;
        logic [31:0]    value;
        logic [3:0]     position;
        bit             filling;
        filling = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            offer_item(directed_rows[i].kind, directed_rows[i].value,
                       directed_rows[i].position, directed_rows[i].pinned,
                       directed_rows[i].want);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 6;  recv_idle_pct = 82; end
                1: begin send_idle_pct = 82; recv_idle_pct = 6;  end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_request  = 1'b1;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // alternate bursts that fill the set and bursts that drain it
                if (n % 30 == 0) filling = ~filling;
                roll = $urandom_range(0, 99);
                if (roll < (filling ? 60 : 15)) kind = oss_pkg::KIND_INSERT;
                else if (roll < (filling ? 75 : 70)) kind = oss_pkg::KIND_REMOVE;
                else if (roll < 87) kind = oss_pkg::KIND_QUERY;
                else kind = oss_pkg::KIND_READ;
                value = pick_value();
                if (held_count != 0 && $urandom_range(0, 3) != 0)
                    position = 4'($urandom_range(0, held_count - 1));
                else
                    position = 4'($urandom_range(0, 15));
                offer_item(kind, value, position, 1'b0, NO_WANT);
            end
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- ordered_set_store.f -----
src/oss_pkg.sv
src/oss_ram.sv
src/ordered_set_store.sv
dv/tb_ordered_set_store.sv
